@@ design/stbs_pkg.sv @@
// Shared types and constants for the sorted table bound search block.
`timescale 1ns / 1ps

package stbs_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 1024;
   localparam int VALUE_W = 32;
   localparam int INDEX_W = 12;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_RIGHT  = 2'd2,
      OP_LEFT   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_SEARCH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic start;
      logic probe;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic start_search;
      logic probe_more;
      logic out_free;
   } stat_type;

endpackage

@@ design/stbs_if.sv @@
// Request and response channel interfaces for the sorted table bound search block.
`timescale 1ns / 1ps

interface stbs_req_if;
   logic                                valid;
   logic                                ready;
   stbs_pkg::opcode_type                opcode;
   logic signed [stbs_pkg::VALUE_W-1:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink (input valid, input opcode, input value, output ready);
endinterface

interface stbs_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [stbs_pkg::INDEX_W-1:0] index;
   logic                                status;

   modport source (output valid, output index, output status, input ready);
   modport sink (input valid, input index, input status, output ready);
endinterface

@@ design/stbs_controller.sv @@
// Sequencing state machine for the sorted table bound search block.
`timescale 1ns / 1ps

module stbs_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  stbs_pkg::stat_type stat,
   output stbs_pkg::cmd_type  cmd
);
   import stbs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = stat.start_search ? ST_SEARCH : ST_DONE;
         end
         ST_SEARCH: begin
            state_in = stat.probe_more ? ST_SEARCH : ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = (state_ff == ST_IDLE) && !reset;
      cmd.capture = (state_ff == ST_IDLE) && !reset && req_valid;
      cmd.start   = (state_ff == ST_START);
      cmd.probe   = (state_ff == ST_SEARCH);
      cmd.load    = (state_ff == ST_DONE) && stat.out_free;
   end

endmodule

@@ design/stbs_datapath.sv @@
// Table memory, bisection bounds and response register for the bound search block.
`timescale 1ns / 1ps

module stbs_datapath #(
   parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  stbs_pkg::cmd_type                   cmd,
   output stbs_pkg::stat_type                  stat,
   input  stbs_pkg::opcode_type                req_opcode,
   input  logic signed [stbs_pkg::VALUE_W-1:0] req_value,
   stbs_rsp_if.source                          rsp
);
   import stbs_pkg::*;

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int BW     = CNT_W + 1;
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic signed [BW-1:0] ONE = BW'(1);

   logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];

   opcode_type                op_ff;
   logic signed [VALUE_W-1:0] key_ff;
   logic [CNT_W-1:0]          count_ff;
   logic signed [BW-1:0]      low_ff;
   logic signed [BW-1:0]      high_ff;
   logic signed [BW-1:0]      mid_ff;
   logic signed [VALUE_W-1:0] rd_ff;
   logic signed [INDEX_W-1:0] res_index_ff;
   logic                      res_status_ff;
   logic                      out_valid_ff;
   logic signed [INDEX_W-1:0] out_index_ff;
   logic                      out_status_ff;

   logic                 full;
   logic                 is_query;
   logic                 is_left;
   logic signed [BW-1:0] high0;
   logic signed [BW-1:0] mid0;
   logic                 go_right;
   logic signed [BW-1:0] mid_p1;
   logic signed [BW-1:0] mid_m1;
   logic [BW:0]          sum_r;
   logic [BW:0]          sum_l;
   logic signed [BW-1:0] r_mid;
   logic signed [BW-1:0] l_mid;
   logic                 r_more;
   logic                 l_more;
   logic signed [BW-1:0] low_n;
   logic signed [BW-1:0] high_n;
   logic signed [BW-1:0] mid_n;
   logic                 more;
   logic signed [BW-1:0] fin_low;
   logic signed [BW-1:0] ans;
   logic signed [31:0]   ans_w;
   logic [ADDR_W-1:0]    rd_addr;

   always_comb begin
      full     = (count_ff == CNT_W'(TABLE_DEPTH));
      is_query = (op_ff == OP_RIGHT) || (op_ff == OP_LEFT);
      is_left  = (op_ff == OP_LEFT);
      high0    = $signed({1'b0, count_ff}) - ONE;
      mid0     = high0 >>> 1;
      go_right = is_left ? (rd_ff <= key_ff) : (rd_ff < key_ff);
      mid_p1   = mid_ff + ONE;
      mid_m1   = mid_ff - ONE;
      sum_r    = {mid_p1[BW-1], mid_p1} + {high_ff[BW-1], high_ff};
      sum_l    = {low_ff[BW-1], low_ff} + {mid_m1[BW-1], mid_m1};
      r_mid    = sum_r[BW:1];
      l_mid    = sum_l[BW:1];
      r_more   = (mid_p1 <= high_ff);
      l_more   = (low_ff <= mid_m1);
      low_n    = go_right ? mid_p1 : low_ff;
      high_n   = go_right ? high_ff : mid_m1;
      mid_n    = go_right ? r_mid : l_mid;
      more     = go_right ? r_more : l_more;
      fin_low  = cmd.start ? '0 : low_n;
      ans      = is_left ? (fin_low - ONE) : fin_low;
      ans_w    = 32'(ans);
      rd_addr  = cmd.start ? mid0[ADDR_W-1:0] : mid_n[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.start && (op_ff == OP_APPEND) && !full) begin
         mem[count_ff[ADDR_W-1:0]] <= key_ff;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.start) begin
         if (op_ff == OP_CLEAR) begin
            count_ff <= '0;
         end else if ((op_ff == OP_APPEND) && !full) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_opcode;
         key_ff <= req_value;
      end
      if (cmd.start) begin
         case (op_ff)
            OP_CLEAR: begin
               res_index_ff  <= '0;
               res_status_ff <= 1'b0;
            end
            OP_APPEND: begin
               res_index_ff  <= '0;
               res_status_ff <= full;
            end
            default: begin
               low_ff        <= '0;
               high_ff       <= high0;
               mid_ff        <= mid0;
               res_index_ff  <= ans_w[INDEX_W-1:0];
               res_status_ff <= 1'b0;
            end
         endcase
      end
      if (cmd.probe) begin
         low_ff        <= low_n;
         high_ff       <= high_n;
         mid_ff        <= mid_n;
         res_index_ff  <= ans_w[INDEX_W-1:0];
         res_status_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_index_ff  <= res_index_ff;
         out_status_ff <= res_status_ff;
      end
   end

   always_comb begin
      stat.start_search = is_query && (count_ff != '0);
      stat.probe_more   = more;
      stat.out_free     = !out_valid_ff || rsp.ready;
      rsp.valid         = out_valid_ff;
      rsp.index         = out_index_ff;
      rsp.status        = out_status_ff;
   end

endmodule

@@ design/sorted_table_bound_search.sv @@
// Top level of the sorted table bound search block.
//
// Keeps a table of signed 32-bit entries and an entry count. Each request on
// req_if carries an opcode and a value: clear, append, first index not below
// the key, or last index not above the key. Every request yields exactly one
// response on rsp_if with a 12-bit signed index and a full-table status flag.
//
// A request is taken only while the sequencer is idle. Clear and append pass
// through the start and done states of the sequencer before the response is
// valid. A query on a table of n entries runs one bisection probe per cycle
// through the registered read port of the table memory, about ceil(log2(n+1))
// probes, between the start and done states. The next request is accepted in
// the cycle after the response is loaded.
//
// Reset empties the table (count to zero) and drops any pending response.
// When the receiver stalls, the response register holds its item; the block
// still accepts and works one more request and waits with its result until
// the response register frees up.
`timescale 1ns / 1ps

module sorted_table_bound_search #(
   parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   stbs_req_if.sink   req_if,
   stbs_rsp_if.source rsp_if
);
   import stbs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   stbs_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   stbs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_opcode (req_if.opcode),
      .req_value  (req_if.value),
      .rsp        (rsp_if)
   );

endmodule

@@ design/stbs_checker.sv @@
// Port-level assertions for the sorted table bound search block, bound to the top level.
`timescale 1ns / 1ps

module stbs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [stbs_pkg::INDEX_W-1:0] rsp_index,
   input logic                                rsp_status
);
   import stbs_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_index) && $stable(rsp_status)))
      else $error("stalled response changed");

   a_drop_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_index == '0))
      else $error("dropped append with nonzero index");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous still in work");

endmodule

bind sorted_table_bound_search stbs_checker u_stbs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_index  (rsp_if.index),
   .rsp_status (rsp_if.status)
);

@@ sim/sorted_table_bound_search_tb.sv @@
// Self-checking testbench for the sorted table bound search block.
`timescale 1ns / 1ps

module sorted_table_bound_search_tb;
   import stbs_pkg::*;

   localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
   localparam int RANDOM_REQUESTS = 600;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic signed [INDEX_W-1:0] index;
      logic                      status;
   } bound_result_type;

   typedef struct packed {
      opcode_type                op;
      logic signed [VALUE_W-1:0] value;
      logic                      literal;
      logic signed [INDEX_W-1:0] want_index;
      logic                      want_status;
   } directed_row_type;

   logic clock;
   logic reset;

   stbs_req_if req_ch ();
   stbs_rsp_if rsp_ch ();

   sorted_table_bound_search #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   logic signed [VALUE_W-1:0] shadow_table [TABLE_DEPTH];
   int                        shadow_count;
   bound_result_type          pending_bounds [$];

   int          requests_sent;
   int          queries_sent;
   int          full_drops;
   int          responses_checked;
   int          fault_count;
   int unsigned burst_left;
   int unsigned sink_run;
   int unsigned sink_mode;

   directed_row_type directed_rows [25] = '{
      '{OP_RIGHT,  32'sd0,     1'b1, 12'sd0,  1'b0},
      '{OP_LEFT,   32'sd0,     1'b1, -12'sd1, 1'b0},
      '{OP_APPEND, VALUE_MIN,  1'b1, 12'sd0,  1'b0},
      '{OP_APPEND, -32'sd5,    1'b1, 12'sd0,  1'b0},
      '{OP_APPEND, 32'sd0,     1'b1, 12'sd0,  1'b0},
      '{OP_APPEND, 32'sd7,     1'b1, 12'sd0,  1'b0},
      '{OP_APPEND, 32'sd7,     1'b1, 12'sd0,  1'b0},
      '{OP_APPEND, VALUE_MAX,  1'b1, 12'sd0,  1'b0},
      '{OP_RIGHT,  VALUE_MIN,  1'b1, 12'sd0,  1'b0},
      '{OP_LEFT,   VALUE_MIN,  1'b1, 12'sd0,  1'b0},
      '{OP_RIGHT,  VALUE_MAX,  1'b1, 12'sd5,  1'b0},
      '{OP_LEFT,   VALUE_MAX,  1'b1, 12'sd5,  1'b0},
      '{OP_RIGHT,  32'sd7,     1'b0, 12'sd0,  1'b0},
      '{OP_LEFT,   32'sd7,     1'b0, 12'sd0,  1'b0},
      '{OP_RIGHT,  -32'sd4,    1'b0, 12'sd0,  1'b0},
      '{OP_LEFT,   -32'sd6,    1'b0, 12'sd0,  1'b0},
      '{OP_RIGHT,  32'sd8,     1'b0, 12'sd0,  1'b0},
      '{OP_LEFT,   -32'sd1,    1'b0, 12'sd0,  1'b0},
      '{OP_APPEND, -32'sd100,  1'b1, 12'sd0,  1'b0},
      '{OP_LEFT,   32'sd0,     1'b0, 12'sd0,  1'b0},
      '{OP_RIGHT,  -32'sd100,  1'b0, 12'sd0,  1'b0},
      '{OP_CLEAR,  32'sd0,     1'b1, 12'sd0,  1'b0},
      '{OP_LEFT,   VALUE_MAX,  1'b1, -12'sd1, 1'b0},
      '{OP_RIGHT,  VALUE_MIN,  1'b1, 12'sd0,  1'b0},
      '{OP_APPEND, -32'sd1,    1'b1, 12'sd0,  1'b0}
   };

   always #5 clock = ~clock;

   function automatic int bisect_low(input logic signed [VALUE_W-1:0] key, input bit inclusive);
      int                        low;
      int                        high;
      int                        mid;
      logic signed [VALUE_W-1:0] entry;
      bit                        move_right;
      low = 0;
      high = shadow_count - 1;
      while (low <= high) begin
         mid = (low + high) / 2;
         entry = shadow_table[mid];
         move_right = inclusive ? (entry <= key) : (entry < key);
         if (move_right) begin
            low = mid + 1;
         end else begin
            high = mid - 1;
         end
      end
      return low;
   endfunction

   function automatic bound_result_type apply_table_op(input opcode_type op,
                                                       input logic signed [VALUE_W-1:0] value);
      bound_result_type res;
      res = '0;
      case (op)
         OP_CLEAR: begin
            shadow_count = 0;
         end
         OP_APPEND: begin
            if (shadow_count < TABLE_DEPTH) begin
               shadow_table[shadow_count] = value;
               shadow_count++;
            end else begin
               res.status = 1'b1;
            end
         end
         OP_RIGHT: begin
            res.index = INDEX_W'(bisect_low(value, 1'b0));
         end
         default: begin
            res.index = INDEX_W'(bisect_low(value, 1'b1) - 1);
         end
      endcase
      return res;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_key();
      int unsigned               pick;
      logic signed [VALUE_W-1:0] key;
      pick = $urandom_range(0, 9);
      key = $urandom();
      if (shadow_count > 0 && pick < 6) begin
         key = shadow_table[$urandom_range(0, shadow_count - 1)];
         if (pick == 3 || pick == 4) begin
            key = key + 1;
         end else if (pick == 5) begin
            key = key - 1;
         end
      end else if (pick == 6) begin
         key = VALUE_MIN;
      end else if (pick == 7) begin
         key = VALUE_MAX;
      end else if (pick == 8) begin
         key = $signed(VALUE_W'($urandom_range(0, 200))) - 100;
      end
      return key;
   endfunction

   task automatic issue_request(input opcode_type op, input logic signed [VALUE_W-1:0] value,
                                input bit literal = 1'b0,
                                input bound_result_type literal_result = '0);
      bound_result_type predicted;
      int unsigned      gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         repeat (gap) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= op;
      req_ch.value  <= value;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      predicted = apply_table_op(op, value);
      pending_bounds.push_back(literal ? literal_result : predicted);
      requests_sent++;
      if (op == OP_RIGHT || op == OP_LEFT) begin
         queries_sent++;
      end
      if (predicted.status) begin
         full_drops++;
      end
   endtask

   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (pending_bounds.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic append_sorted_run(input int count);
      longint      acc;
      int unsigned spread;
      case ($urandom_range(0, 2))
         0:       spread = 2;
         1:       spread = 1000;
         default: spread = 1 << 24;
      endcase
      acc = $urandom_range(0, 1) ? longint'($signed($urandom()))
                                 : longint'($urandom_range(0, 200)) - 100;
      repeat (count) begin
         acc += $urandom_range(0, spread);
         if (acc > longint'(VALUE_MAX)) begin
            acc = longint'(VALUE_MAX);
         end
         issue_request(OP_APPEND, VALUE_W'(acc));
      end
   endtask

   always @(posedge clock) begin
      if (sink_run == 0) begin
         sink_mode = $urandom_range(0, 3);
         sink_run = $urandom_range(4, 60);
      end
      sink_run--;
      case (sink_mode)
         0:       rsp_ch.ready <= 1'b1;
         1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         2:       rsp_ch.ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ch.ready <= sink_run[2];
      endcase
   end

   always @(posedge clock) begin : rsp_check
      bound_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_bounds.size() == 0) begin
            if (fault_count < 10) begin
               $display("%0t: unexpected response index=%0d status=%0d", $realtime,
                        rsp_ch.index, rsp_ch.status);
            end
            fault_count++;
         end else begin
            want = pending_bounds.pop_front();
            responses_checked++;
            if (rsp_ch.index !== want.index || rsp_ch.status !== want.status) begin
               if (fault_count < 10) begin
                  $display({"%0t: response mismatch: expected index=%0d status=%0d, ",
                            "got index=%0d status=%0d"},
                           $realtime, want.index, want.status, rsp_ch.index, rsp_ch.status);
               end
               fault_count++;
            end
         end
      end
   end

   initial begin
      #6_000_000;
      $display("[sorted_table_bound_search] ERROR");
      $finish;
   end

   initial begin
      int          random_start;
      int unsigned kind;
      int          count;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_CLEAR;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
      shadow_count = 0;
      requests_sent = 0;
      queries_sent = 0;
      full_drops = 0;
      responses_checked = 0;
      fault_count = 0;
      burst_left = 0;
      sink_run = 0;
      sink_mode = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         issue_request(directed_rows[r].op, directed_rows[r].value, directed_rows[r].literal,
                       {directed_rows[r].want_index, directed_rows[r].want_status});
      end
      drain_responses();

      // fill the table to the brim, then push past it
      issue_request(OP_CLEAR, $urandom());
      append_sorted_run(TABLE_DEPTH);
      repeat (3) issue_request(OP_APPEND, $urandom());
      issue_request(OP_RIGHT, VALUE_MIN);
      issue_request(OP_LEFT, VALUE_MIN);
      issue_request(OP_RIGHT, VALUE_MAX);
      issue_request(OP_LEFT, VALUE_MAX);
      repeat (12) issue_request(opcode_type'($urandom_range(2, 3)), pick_key());
      drain_responses();

      random_start = requests_sent;
      while (requests_sent - random_start < RANDOM_REQUESTS) begin
         kind = $urandom_range(0, 9);
         if (kind <= 7) begin
            issue_request(OP_CLEAR, $urandom());
            count = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 16);
            if (kind <= 5) begin
               append_sorted_run(count);
            end else begin
               repeat (count) begin
                  issue_request(OP_APPEND, $urandom_range(0, 1) ? $urandom()
                                : $signed(VALUE_W'($urandom_range(0, 40))) - 20);
               end
            end
            repeat ($urandom_range(4, 20)) begin
               issue_request(opcode_type'($urandom_range(2, 3)), pick_key());
            end
         end else begin
            repeat ($urandom_range(3, 15)) begin
               issue_request(opcode_type'($urandom_range(0, 3)), $urandom());
            end
         end
         if ($urandom_range(0, 3) == 0) begin
            drain_responses();
         end
      end

      drain_responses();
      repeat (40) @(posedge clock);

      $display("Run covered %0d requests (%0d queries, %0d appends dropped on a full table).",
               requests_sent, queries_sent, full_drops);
      $display("Checked %0d responses, %0d failures.", responses_checked, fault_count);
      if (fault_count == 0 && pending_bounds.size() == 0) begin
         $display("[sorted_table_bound_search] OK");
      end else begin
         $display("[sorted_table_bound_search] ERROR");
      end
      $finish;
   end

endmodule
